// ===== design/b62enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b62enc_pkg: shared constants and helpers for the base-62 encoder
// Digit and character widths, the radix, the shuffled alphabet and the
// digit-to-character lookup used by the emit side.
// ----------------------------------------------------------------------------
package b62enc_pkg;

  localparam int DIGIT_W       = 6;
  localparam int CHAR_W        = 8;
  localparam int RADIX         = 62;
  localparam int HALF_RADIX    = RADIX / 2;
  // input bits folded into the digit vector per conversion cycle
  localparam int BITS_PER_STEP = 4;
  // entries in the queue between converter and emitter (power of two)
  localparam int QUEUE_DEPTH   = 2;

  // shuffled alphabet, digit 0 in the top byte
  localparam logic [CHAR_W*RADIX-1:0] ALPHABET =
    "vPh7zZwA2LyU4bGq5tcVfIMxJi6XaSoK9CNp0OWljYTHQ8REnmu31BrdgeDkFs";

  // map one digit to its alphabet character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] rev;
    rev = DIGIT_W'(RADIX - 1) - d;
    if (d > DIGIT_W'(RADIX - 1)) begin
      return '0;
    end
    return ALPHABET[rev*CHAR_W +: CHAR_W];
  endfunction

endpackage

// ===== design/b62enc_front.sv =====
// ----------------------------------------------------------------------------
// b62enc_front: value to base-62 digit converter
// Shifts the input in MSB first, a few bits per cycle, doubling the digit
// vector and adding the bit (digit-wise carries, no ripple). Hands the
// finished digit vector and the index of the leading digit to the queue.
// ----------------------------------------------------------------------------
module b62enc_front #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 6
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic [VALUE_BITS-1:0]                       value_i,
  output logic                                        busy_o,
  input  logic                                        full_i,
  output logic                                        push_o,
  output logic [MAX_DIGITS*b62enc_pkg::DIGIT_W-1:0]   digits_o,
  output logic [$clog2(MAX_DIGITS)-1:0]               last_idx_o
);

  localparam int DW       = b62enc_pkg::DIGIT_W;
  localparam int BPS      = b62enc_pkg::BITS_PER_STEP;
  localparam int STEPS    = (VALUE_BITS + BPS - 1) / BPS;
  localparam int PAD_BITS = STEPS * BPS;
  localparam int STEP_W   = $clog2(STEPS);
  localparam int IDX_W    = $clog2(MAX_DIGITS);

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_HOLD} fstate_e;

  fstate_e             state_q;
  logic [PAD_BITS-1:0] shift_q;
  logic [STEP_W-1:0]   cnt_q;
  logic [DW-1:0]       digits_q [MAX_DIGITS];
  logic [DW-1:0]       digits_d [MAX_DIGITS];
  logic                ovf_q;
  logic                ovf_d;

  // fold the next input bits into the digit vector, MSB first
  always_comb begin
    logic [MAX_DIGITS-1:0] cy;
    logic [DW:0]           sum;
    logic                  cin;
    digits_d = digits_q;
    ovf_d    = ovf_q;
    for (int b = 0; b < BPS; b++) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        cy[i] = digits_d[i] >= DW'(b62enc_pkg::HALF_RADIX);
      end
      ovf_d = ovf_d | cy[MAX_DIGITS-1];
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (i == 0) begin
          cin = shift_q[PAD_BITS-1-b];
        end else begin
          cin = cy[i-1];
        end
        sum = {digits_d[i], cin};
        if (cy[i]) begin
          digits_d[i] = DW'(sum - (DW+1)'(b62enc_pkg::RADIX));
        end else begin
          digits_d[i] = DW'(sum);
        end
      end
    end
  end

  // find the leading digit; a value past the digit range keeps full width
  always_comb begin
    last_idx_o = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digits_q[i] != '0) begin
        last_idx_o = IDX_W'(i);
      end
    end
    if (ovf_q) begin
      last_idx_o = IDX_W'(MAX_DIGITS - 1);
    end
  end

  // pack the digit vector for the queue
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digits_o[i*DW +: DW] = digits_q[i];
    end
  end

  assign busy_o = (state_q != F_IDLE);
  assign push_o = (state_q == F_HOLD) && !full_i;

  // sequence: load, convert, hold until the queue has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (start_i) begin
            state_q <= F_CONV;
            cnt_q   <= STEP_W'(STEPS - 1);
          end
        end
        F_CONV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= F_HOLD;
          end
        end
        F_HOLD: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  // datapath: shift register, digit vector and overflow flag
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start_i) begin
      shift_q  <= PAD_BITS'(value_i);
      digits_q <= '{default: '0};
      ovf_q    <= 1'b0;
    end else if (state_q == F_CONV) begin
      shift_q  <= shift_q << BPS;
      digits_q <= digits_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

// ===== design/b62enc_fifo.sv =====
// ----------------------------------------------------------------------------
// b62enc_fifo: short word queue between converter and emitter
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module b62enc_fifo #(
  parameter int WIDTH = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int DEPTH = b62enc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue popped while empty");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q <= CNT_W'(DEPTH)) && !empty_o)
    else $error("queue level out of range after push");

endmodule

// ===== design/b62enc_back.sv =====
// ----------------------------------------------------------------------------
// b62enc_back: digit emitter
// Takes a digit vector from the queue and strobes its digits out, leading
// digit first, one per cycle, with the alphabet character and last flag.
// ----------------------------------------------------------------------------
module b62enc_back #(
  parameter int MAX_DIGITS = 6
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        empty_i,
  input  logic [MAX_DIGITS*b62enc_pkg::DIGIT_W-1:0]   digits_i,
  input  logic [$clog2(MAX_DIGITS)-1:0]               last_idx_i,
  output logic                                        pop_o,
  output logic                                        digit_valid_o,
  output logic [b62enc_pkg::CHAR_W-1:0]               digit_char_o,
  output logic [b62enc_pkg::DIGIT_W-1:0]              digit_value_o,
  output logic                                        last_digit_o
);

  localparam int DW    = b62enc_pkg::DIGIT_W;
  localparam int IDX_W = $clog2(MAX_DIGITS);

  typedef enum logic {B_IDLE, B_EMIT} bstate_e;

  bstate_e          state_q;
  logic [IDX_W-1:0] idx_q;
  logic [DW-1:0]    digs_q [MAX_DIGITS];
  logic [DW-1:0]    sel;

  assign sel   = digs_q[idx_q];
  // take the next word when idle or on the final digit of the current one
  assign pop_o = ((state_q == B_IDLE) || (idx_q == '0)) && !empty_i;

  // hold the digit vector being emitted
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digs_q[i] <= digits_i[i*DW +: DW];
      end
    end
  end

  // emit sequence and registered result outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= B_IDLE;
      idx_q         <= '0;
      digit_valid_o <= 1'b0;
      digit_char_o  <= '0;
      digit_value_o <= '0;
      last_digit_o  <= 1'b0;
    end else begin
      digit_valid_o <= (state_q == B_EMIT);
      digit_value_o <= sel;
      digit_char_o  <= b62enc_pkg::digit_char(sel);
      last_digit_o  <= (state_q == B_EMIT) && (idx_q == '0);
      case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            state_q <= B_EMIT;
            idx_q   <= last_idx_i;
          end
        end
        B_EMIT: begin
          if (pop_o) begin
            idx_q <= last_idx_i;
          end else if (idx_q == '0) begin
            state_q <= B_IDLE;
          end else begin
            idx_q <= idx_q - 1'b1;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/base62_integer_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// base62_integer_encoder_unit: integer to shuffled base-62 character string
// Flow: start loads the converter, which folds four input bits per cycle
// into the digit vector, then waits for room and pushes it into the queue;
// the emitter pops it and strobes one digit per cycle, alongside. A new
// value is taken only after the converter has pushed the last one.
// Reset clears all control state; the queue comes up empty, no strobes.
// ----------------------------------------------------------------------------
module base62_integer_encoder_unit #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  logic [VALUE_BITS-1:0]              value_i,
  output logic                               busy,
  output logic                               digit_valid_o,
  output logic [b62enc_pkg::CHAR_W-1:0]      digit_char_o,
  output logic [b62enc_pkg::DIGIT_W-1:0]     digit_value_o,
  output logic                               last_digit_o
);

  localparam int DW     = b62enc_pkg::DIGIT_W;
  localparam int IDX_W  = $clog2(MAX_DIGITS);
  localparam int VEC_W  = MAX_DIGITS * DW;
  localparam int WORD_W = VEC_W + IDX_W;

  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  logic [VEC_W-1:0]  f_digits;
  logic [IDX_W-1:0]  f_last_idx;
  logic [WORD_W-1:0] q_rdata;

  b62enc_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .value_i    (value_i),
    .busy_o     (busy),
    .full_i     (full),
    .push_o     (push),
    .digits_o   (f_digits),
    .last_idx_o (f_last_idx)
  );

  b62enc_fifo #(
    .WIDTH(WORD_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_last_idx, f_digits}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  b62enc_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .digits_i      (q_rdata[VEC_W-1:0]),
    .last_idx_i    (q_rdata[WORD_W-1:VEC_W]),
    .pop_o         (pop),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .digit_value_o (digit_value_o),
    .last_digit_o  (last_digit_o)
  );

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("converter not busy after accepting a value");

  a_digits_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_valid_o && !last_digit_o) |=> digit_valid_o)
    else $error("gap inside the digits of one value");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |-> (digit_value_o <= DW'(b62enc_pkg::RADIX - 1)))
    else $error("digit value out of base-62 range");

endmodule
